>>> design/mtrg_pkg.sv
// Shared constants and word functions of the MT19937 generator.
`timescale 1ns / 1ps
package mtrg_pkg;

  localparam int unsigned StateWords  = 624;
  localparam int unsigned ShiftOffset = 397;

  localparam logic [31:0] TwistMatrix  = 32'h9908b0df;
  localparam logic [31:0] HighBit      = 32'h80000000;
  localparam logic [31:0] LowBits      = 32'h7fffffff;
  localparam logic [31:0] TemperB      = 32'h9d2c5680;
  localparam logic [31:0] TemperC      = 32'hefc60000;
  localparam logic [31:0] SeedMult     = 32'd69069;
  localparam logic [31:0] DefaultSeedRst = 32'd4357;

  // New value of one store word from its old self, its successor and the far word.
  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & HighBit) | (nxt & LowBits);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TwistMatrix;
    end
    return v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> design/mt19937_random_generator_top.sv
// MT19937 generator: request handling, seeding and twist sequencer, tempering and output.
// A draw request stalls the input until its word is registered: the accepting cycle issues
// the state memory read, and the output state tempers and registers the word once the
// result register is free. A reseed request stalls the input after acceptance for
// one memory write per word of the seed recurrence. The first draw after a reseed, or
// after all words are used, also runs the twist over the whole store (two priming reads,
// then one word a cycle) before its own read; a draw that comes before any reseed
// first seeds from the default seed and then twists. The rate of all of
// this is set by the single write port of the 624-word state memory. The default
// seed register may be written at any time the block is idle and is always ready.
`timescale 1ns / 1ps
module mt19937_random_generator_top #(
  parameter int unsigned STATE_WORDS = mtrg_pkg::StateWords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] seed_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o,
  // default seed register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_default_seed_i
);
  import mtrg_pkg::*;

  localparam int unsigned AddrW = $clog2(STATE_WORDS);
  localparam int unsigned IdxW  = $clog2(STATE_WORDS + 2);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(STATE_WORDS - 1);
  localparam logic [IdxW-1:0]  IdxUsed  = IdxW'(STATE_WORDS);
  localparam logic [IdxW-1:0]  IdxNever = IdxW'(STATE_WORDS + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEED    = 3'd1;
  localparam logic [2:0] S_TW_PRE  = 3'd2;
  localparam logic [2:0] S_TW_CUR  = 3'd3;
  localparam logic [2:0] S_TW_RUN  = 3'd4;
  localparam logic [2:0] S_DRAW_RD = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;

  localparam logic ActReseed = 1'b1;

  logic [2:0]       state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [31:0]      x_q, x_d;
  logic [31:0]      cur_q, cur_d;
  logic             pend_q, pend_d;
  logic [31:0]      dseed_q;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      out_q, out_d;

  logic             in_acc;
  logic             out_free;
  logic [31:0]      seed_pick;

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      wdata;
  logic             re_a, re_b;
  logic [AddrW-1:0] raddr_a, raddr_b;
  logic [31:0]      rdata_a, rdata_b;

  logic [AddrW-1:0] step_j;
  logic [AddrW:0]   far_sum;
  logic [AddrW-1:0] nxt_addr, far_addr;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign seed_pick   = (seed_value_i == 32'd0) ? dseed_q : seed_value_i;

  // addresses for the twist step being issued
  assign step_j   = (state_q == S_TW_CUR) ? '0 : k_q + AddrW'(1);
  assign nxt_addr = (step_j == LastAddr) ? '0 : step_j + AddrW'(1);
  assign far_sum  = {1'b0, step_j} + (AddrW + 1)'(ShiftOffset);
  assign far_addr = (far_sum >= (AddrW + 1)'(STATE_WORDS)) ?
                    AddrW'(far_sum - (AddrW + 1)'(STATE_WORDS)) : far_sum[AddrW-1:0];

  mtrg_store #(
    .Depth (STATE_WORDS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_a_i    (re_a),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (re_b),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    k_d         = k_q;
    x_d         = x_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = k_q;
    wdata       = x_q;
    re_a        = 1'b0;
    raddr_a     = idx_q[AddrW-1:0];
    re_b        = 1'b0;
    raddr_b     = far_addr;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (action_i == ActReseed) begin
            x_d     = seed_pick;
            k_d     = '0;
            pend_d  = 1'b0;
            state_d = S_SEED;
          end else if (idx_q == IdxNever) begin
            x_d     = dseed_q;
            k_d     = '0;
            pend_d  = 1'b1;
            state_d = S_SEED;
          end else if (idx_q == IdxUsed) begin
            state_d = S_TW_PRE;
          end else begin
            re_a    = 1'b1;
            state_d = S_OUT;
          end
        end
      end
      S_SEED: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = x_q;
        x_d   = x_q * SeedMult;
        if (k_q == LastAddr) begin
          idx_d   = IdxUsed;
          state_d = pend_q ? S_TW_PRE : S_IDLE;
        end else begin
          k_d = k_q + AddrW'(1);
        end
      end
      S_TW_PRE: begin
        re_a    = 1'b1;
        raddr_a = '0;
        state_d = S_TW_CUR;
      end
      S_TW_CUR: begin
        // old word 0 arrives; issue reads for step 0
        cur_d   = rdata_a;
        re_a    = 1'b1;
        raddr_a = nxt_addr;
        re_b    = 1'b1;
        k_d     = '0;
        state_d = S_TW_RUN;
      end
      S_TW_RUN: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = twist_word(cur_q, rdata_a, rdata_b);
        cur_d = rdata_a;
        if (k_q == LastAddr) begin
          idx_d   = '0;
          state_d = S_DRAW_RD;
        end else begin
          re_a    = 1'b1;
          raddr_a = nxt_addr;
          re_b    = 1'b1;
          k_d     = step_j;
        end
      end
      S_DRAW_RD: begin
        re_a    = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d       = temper(rdata_a);
          out_valid_d = 1'b1;
          idx_d       = idx_q + IdxW'(1);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= IdxNever;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      dseed_q     <= DefaultSeedRst;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dseed_q <= cfg_default_seed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    x_q   <= x_d;
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_q;

  // the twist pipeline must never read a word in the cycle it is rewritten
  a_no_rw_clash_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re_a) |-> (waddr != raddr_a))
    else $error("store write and port A read hit the same word");

  a_no_rw_clash_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re_b) |-> (waddr != raddr_b))
    else $error("store write and port B read hit the same word");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxNever)
    else $error("word index out of range");

  a_twist_done_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TW_RUN && k_q == LastAddr) |=> (idx_q == '0 && state_q == S_DRAW_RD))
    else $error("twist end did not rewind the word index");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |-> $past(state_q == S_OUT))
    else $error("result produced outside the output state");

endmodule

>>> design/mtrg_store.sv
// Generator state memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module mtrg_store #(
  parameter int unsigned Depth = 624,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic             re_a_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [31:0]      rdata_a_o,
  input  logic             re_b_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [31:0]      rdata_b_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while the port is not enabled
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> dv/tb_mt19937_random_generator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the MT19937 generator top level.
module tb_mt19937_random_generator_top;
  import mtrg_pkg::*;

  localparam bit          ActDraw     = 1'b0;
  localparam bit          ActReseed   = 1'b1;
  localparam logic [9:0]  Unseeded    = 10'(StateWords + 1);
  // a reseed gives no result, so allow for one full seeding pass plus a twist
  localparam int unsigned DrainCycles = 1400;
  localparam int unsigned CycleLimit  = 6_000_000;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic        action_i           = 1'b0;
  logic [31:0] seed_value_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic [31:0] random_word_o;
  logic        cfg_valid_i        = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_default_seed_i = '0;

  // predictor state
  logic [31:0] mt_store [StateWords];
  logic [9:0]  mt_pos;
  logic [31:0] seed_reg;

  logic [31:0] expected_words [$];
  logic [31:0] exp_word;
  int unsigned failures   = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  bit          no_idle    = 1'b0;

  mt19937_random_generator_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .seed_value_i      (seed_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .random_word_o     (random_word_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_default_seed_i(cfg_default_seed_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // seed 0 a quarter of the time, so the default seed gets used often
  function automatic logic [31:0] pick_seed();
    return ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
  endfunction

  function automatic void load_seed(input logic [31:0] s);
    mt_store[0] = s;
    for (int i = 1; i < StateWords; i++) begin
      mt_store[i] = mt_store[i-1] * SeedMult;
    end
    mt_pos = 10'(StateWords);
  endfunction

  // in place, so late words see already updated early ones
  function automatic void twist_store();
    logic [31:0] y;
    logic [31:0] v;
    for (int k = 0; k < StateWords; k++) begin
      y = (mt_store[k] & HighBit) | (mt_store[(k + 1) % StateWords] & LowBits);
      v = mt_store[(k + ShiftOffset) % StateWords] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TwistMatrix;
      end
      mt_store[k] = v;
    end
    mt_pos = '0;
  endfunction

  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    return y ^ (y >> 18);
  endfunction

  function automatic logic [31:0] draw_word();
    logic [31:0] w;
    if (mt_pos >= 10'(StateWords)) begin
      if (mt_pos != 10'(StateWords)) begin
        load_seed(seed_reg);
      end
      twist_store();
    end
    w = mt_store[mt_pos];
    mt_pos = mt_pos + 10'd1;
    return mt_temper(w);
  endfunction

  // result side: stall for a drawn number of cycles after each accepted word
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("random_word: no word expected, actual %h", random_word_o);
        failures++;
      end else begin
        exp_word = expected_words.pop_front();
        if (random_word_o !== exp_word) begin
          $error("random_word: expected %h, actual %h", exp_word, random_word_o);
          failures++;
        end
      end
      stall_left = idle_gap();
    end
  end

  task automatic send_request(input bit act, input logic [31:0] seed);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    seed_value_i <= seed;
    do @(posedge clk_i); while (in_stall_o);
    if (act == ActReseed) begin
      load_seed((seed == 32'd0) ? seed_reg : seed);
    end else begin
      expected_words.push_back(draw_word());
    end
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_default_seed(input logic [31:0] value);
    drain_block();
    @(negedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_default_seed_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    seed_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // draws with no prior seeding fall back to the reset default seed
  task automatic test_unseeded_draw();
    repeat (3) send_request(ActDraw, $urandom());
  endtask

  task automatic test_seed_extremes();
    send_request(ActReseed, 32'd0);
    send_request(ActDraw, 32'hffffffff);
    send_request(ActReseed, 32'hffffffff);
    send_request(ActDraw, 32'd0);
    send_request(ActDraw, $urandom());
    send_request(ActReseed, 32'd1);
    send_request(ActDraw, $urandom());
    send_request(ActReseed, 32'h80000000);
    send_request(ActDraw, $urandom());
    send_request(ActReseed, 32'h55555555);
    send_request(ActReseed, 32'haaaaaaaa);
    send_request(ActDraw, $urandom());
  endtask

  // zero default seed with a zero seed request leaves an all-zero store
  task automatic test_zero_default();
    write_default_seed(32'd0);
    send_request(ActReseed, 32'd0);
    send_request(ActDraw, $urandom());
    send_request(ActDraw, $urandom());
    write_default_seed(32'hffffffff);
    send_request(ActReseed, 32'd0);
    send_request(ActDraw, $urandom());
  endtask

  // long draw runs so the store is used up and twisted again mid-stream
  task automatic test_exhaustion();
    bit act;
    write_default_seed($urandom());
    send_request(ActReseed, pick_seed());
    for (int i = 0; i < 720; i++) begin
      if (i % 64 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      act = ($urandom_range(0, 255) == 0) ? ActReseed : ActDraw;
      send_request(act, (act == ActReseed) ? pick_seed() : $urandom());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    bit act;
    write_default_seed($urandom());
    for (int i = 0; i < 300; i++) begin
      if (i % 50 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      act = ($urandom_range(0, 9) == 0) ? ActReseed : ActDraw;
      send_request(act, (act == ActReseed) ? pick_seed() : $urandom());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    seed_reg = DefaultSeedRst;
    mt_pos   = Unseeded;
    for (int i = 0; i < StateWords; i++) begin
      mt_store[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unseeded_draw();
    test_seed_extremes();
    test_zero_default();
    test_exhaustion();
    test_random_mix();

    drain_block();
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mtrg_pkg.sv
design/mtrg_store.sv
design/mt19937_random_generator_top.sv
dv/tb_mt19937_random_generator_top.sv
